/* sv/bbc_pkg.sv */
// Shared constants for the binary blob centroid core.
// Field widths, register indexes and reset values; no dependencies.
package bbc_pkg;

  localparam int DIM_W     = 13;
  localparam int LEVEL_W   = 8;
  localparam int CX_W      = 12;
  localparam int CY_W      = 12;
  localparam int TOTAL_W   = 25;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_LEVEL  = 2'd2;

  localparam logic [DIM_W-1:0]   WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]   HEIGHT_RST = 13'd480;
  localparam logic [LEVEL_W-1:0] LEVEL_RST  = 8'hFF;

endpackage

/* sv/bbc_serdiv.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Used by the centroid core for the column and row means; needs no package.
module bbc_serdiv #(
  parameter int QW = 12,
  parameter int DW = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [QW+DW-1:0] dividend_i,
  input  logic [DW-1:0]    divisor_i,
  output logic             busy_o,
  output logic [QW-1:0]    quot_o
);

  localparam int CNTW = (QW > 1) ? $clog2(QW) : 1;

  logic [DW-1:0]   rem_q, rem_d;
  logic [QW-1:0]   dvd_q, dvd_d;
  logic [DW-1:0]   div_q;
  logic [CNTW-1:0] cnt_q;
  logic            run_q;
  logic [DW:0]     trial, diff;
  logic            ge;

  // Dividend bits shift out the top of dvd_q while quotient bits enter at the bottom.
  always_comb begin
    trial = {rem_q, dvd_q[QW-1]};
    diff  = trial - {1'b0, div_q};
    ge    = (trial >= {1'b0, div_q});
    rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
    dvd_d = {dvd_q[QW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + CNTW'(1);
      if (cnt_q == CNTW'(QW - 1)) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[QW+DW-1:QW];
      dvd_q <= dividend_i[QW-1:0];
      div_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  assign busy_o = run_q;
  assign quot_o = dvd_q;

endmodule

/* sv/bbc_accum.sv */
// Configuration registers, raster position tracking and centroid accumulators.
// Depends on bbc_pkg for field widths, register indexes and reset values.
module bbc_accum #(
  parameter int MAX_WIDTH  = bbc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bbc_pkg::MAX_HEIGHT_DEF,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int RW  = $clog2(MAX_HEIGHT),
  localparam int NW  = CW + RW + 1,
  localparam int XSW = 2 * CW + RW,
  localparam int YSW = CW + 2 * RW
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bbc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bbc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           pix_acc_i,
  input  logic [bbc_pkg::LEVEL_W-1:0]    pixel_value_i,
  output logic                           frame_end_o,
  output logic [XSW-1:0]                 x_sum_o,
  output logic [YSW-1:0]                 y_sum_o,
  output logic [NW-1:0]                  hit_count_o
);

  localparam int DIMW = bbc_pkg::DIM_W;
  localparam int WXW  = (CW + 1 > DIMW) ? CW + 1 : DIMW;
  localparam int WYW  = (RW + 1 > DIMW) ? RW + 1 : DIMW;

  logic [DIMW-1:0]               width_q, height_q;
  logic [bbc_pkg::LEVEL_W-1:0]   level_q;
  logic [CW-1:0]                 col_q, col_d;
  logic [RW-1:0]                 row_q, row_d;
  logic [XSW-1:0]                x_sum_q, x_sum_nx;
  logic [YSW-1:0]                y_sum_q, y_sum_nx;
  logic [NW-1:0]                 cnt_q, cnt_nx;
  logic [WXW-1:0]                w_ext, w_eff, col_inc;
  logic [WYW-1:0]                h_ext, h_eff, row_inc;
  logic                          hit, col_wrap, row_wrap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bbc_pkg::WIDTH_RST;
      height_q <= bbc_pkg::HEIGHT_RST;
      level_q  <= bbc_pkg::LEVEL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bbc_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data_i[DIMW-1:0];
        bbc_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data_i[DIMW-1:0];
        bbc_pkg::REG_MATCH_LEVEL:  level_q  <= cfg_data_i[bbc_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // Zero geometry acts as one; oversize geometry saturates at the maximum.
    w_ext = WXW'(width_q);
    h_ext = WYW'(height_q);
    if (w_ext == '0) begin
      w_eff = WXW'(1);
    end else if (w_ext > WXW'(MAX_WIDTH)) begin
      w_eff = WXW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext == '0) begin
      h_eff = WYW'(1);
    end else if (h_ext > WYW'(MAX_HEIGHT)) begin
      h_eff = WYW'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end

    hit      = (pixel_value_i == level_q);
    x_sum_nx = x_sum_q + (hit ? XSW'(col_q) : '0);
    y_sum_nx = y_sum_q + (hit ? YSW'(row_q) : '0);
    cnt_nx   = cnt_q + (hit ? NW'(1) : '0);

    col_inc  = WXW'(col_q) + WXW'(1);
    row_inc  = WYW'(row_q) + WYW'(1);
    col_wrap = (col_inc >= w_eff);
    row_wrap = (row_inc >= h_eff);

    col_d = col_wrap ? '0 : col_inc[CW-1:0];
    row_d = row_q;
    if (col_wrap) begin
      row_d = row_wrap ? '0 : row_inc[RW-1:0];
    end
  end

  assign frame_end_o = pix_acc_i && col_wrap && row_wrap;
  assign x_sum_o     = x_sum_nx;
  assign y_sum_o     = y_sum_nx;
  assign hit_count_o = cnt_nx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      x_sum_q <= '0;
      y_sum_q <= '0;
      cnt_q   <= '0;
    end else if (pix_acc_i) begin
      col_q <= col_d;
      row_q <= row_d;
      if (frame_end_o) begin
        // Drop the sums once they are handed to the dividers.
        x_sum_q <= '0;
        y_sum_q <= '0;
        cnt_q   <= '0;
      end else begin
        x_sum_q <= x_sum_nx;
        y_sum_q <= y_sum_nx;
        cnt_q   <= cnt_nx;
      end
    end
  end

endmodule

/* sv/binary_blob_centroid_core.sv */
// Binary blob centroid core: one pixel per cycle while a frame streams in.
// After the last pixel of a frame, input stalls while two bit-serial dividers run and
// the result loads into the output register.
// A pending result does not stall input; the next frame end waits for it to drain.
// Async active-low reset clears position, sums and control; geometry 640x480, level 0xFF.
module binary_blob_centroid_core #(
  parameter int MAX_WIDTH  = bbc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bbc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bbc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bbc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bbc_pkg::LEVEL_W-1:0]    pixel_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bbc_pkg::CX_W-1:0]       center_x_o,
  output logic [bbc_pkg::CY_W-1:0]       center_y_o,
  output logic                           found_o,
  output logic [bbc_pkg::TOTAL_W-1:0]    match_total_o
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int NW   = CW + RW + 1;
  localparam int XSW  = 2 * CW + RW;
  localparam int YSW  = CW + 2 * RW;
  localparam int CXW  = bbc_pkg::CX_W;
  localparam int CYW  = bbc_pkg::CY_W;
  localparam int TOTW = bbc_pkg::TOTAL_W;

  localparam logic ST_RUN = 1'b0;
  localparam logic ST_DIV = 1'b1;

  logic            state_q;
  logic            pix_acc, frame_end;
  logic [XSW-1:0]  x_sum;
  logic [YSW-1:0]  y_sum;
  logic [NW-1:0]   hit_count, cnt_q;
  logic            busy_x, busy_y;
  logic [CW-1:0]   quot_x;
  logic [RW-1:0]   quot_y;
  logic            load_out;
  logic            out_valid_q;
  logic [CXW-1:0]  center_x_q;
  logic [CYW-1:0]  center_y_q;
  logic            found_q;
  logic [TOTW-1:0] total_q;

  assign in_ready_o = (state_q == ST_RUN);
  assign pix_acc    = in_valid_i && in_ready_o;

  bbc_accum #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pix_acc_i     (pix_acc),
    .pixel_value_i (pixel_value_i),
    .frame_end_o   (frame_end),
    .x_sum_o       (x_sum),
    .y_sum_o       (y_sum),
    .hit_count_o   (hit_count)
  );

  bbc_serdiv #(
    .QW (CW),
    .DW (NW)
  ) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (frame_end),
    .dividend_i ((CW + NW)'(x_sum)),
    .divisor_i  (hit_count),
    .busy_o     (busy_x),
    .quot_o     (quot_x)
  );

  bbc_serdiv #(
    .QW (RW),
    .DW (NW)
  ) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (frame_end),
    .dividend_i ((RW + NW)'(y_sum)),
    .divisor_i  (hit_count),
    .busy_o     (busy_y),
    .quot_o     (quot_y)
  );

  // Hold the finished quotients until the output register is free.
  assign load_out = (state_q == ST_DIV) && !busy_x && !busy_y &&
                    (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_RUN: begin
          if (frame_end) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (load_out) begin
            state_q <= ST_RUN;
          end
        end
        default: state_q <= ST_RUN;
      endcase
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_end) begin
      cnt_q <= hit_count;
    end
    if (load_out) begin
      center_x_q <= (cnt_q == '0) ? '0 : CXW'(quot_x);
      center_y_q <= (cnt_q == '0) ? '0 : CYW'(quot_y);
      found_q    <= (cnt_q != '0);
      total_q    <= TOTW'(cnt_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign center_x_o    = center_x_q;
  assign center_y_o    = center_y_q;
  assign found_o       = found_q;
  assign match_total_o = total_q;

endmodule

/* sv/bbc_checker.sv */
// Port-level checks for the binary blob centroid core, bound to the top level.
// Depends on bbc_pkg for port widths.
module bbc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [bbc_pkg::CX_W-1:0]       center_x_o,
  input logic [bbc_pkg::CY_W-1:0]       center_y_o,
  input logic                           found_o,
  input logic [bbc_pkg::TOTAL_W-1:0]    match_total_o
);

  // A stalled result request holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(center_x_o) &&
    $stable(center_y_o) && $stable(found_o) && $stable(match_total_o))
    else $error("stalled result changed");

  // An empty frame reports all zero.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> center_x_o == '0 && center_y_o == '0 &&
    match_total_o == '0)
    else $error("empty frame with nonzero result");

  // A result is only loaded during the divide phase, when input is stalled.
  a_result_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared outside the divide phase");

  // Input stalls only after a pixel was taken.
  a_stall_after_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i))
    else $error("input stalled without a frame end");

endmodule

bind binary_blob_centroid_core bbc_checker u_bbc_checker (.*);

/* tb/tb.sv */
// Self-checking testbench for binary_blob_centroid_core: streams pixel frames,
// predicts each frame's centroid and compares it with the core's output.
// Depends on bbc_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;
  import bbc_pkg::*;

  localparam int                   SETTLE_CYCLES = 40;
  localparam int                   CYCLE_LIMIT   = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 2'd3;

  typedef struct packed {
    logic [CX_W-1:0]    cx;
    logic [CY_W-1:0]    cy;
    logic               found;
    logic [TOTAL_W-1:0] total;
  } centroid_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic [LEVEL_W-1:0]    pixel_value_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic [CX_W-1:0]       center_x_o;
  logic [CY_W-1:0]       center_y_o;
  logic                  found_o;
  logic [TOTAL_W-1:0]    match_total_o;

  binary_blob_centroid_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_value_i(pixel_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .center_x_o   (center_x_o),
    .center_y_o   (center_y_o),
    .found_o      (found_o),
    .match_total_o(match_total_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mirror of the core's registers and frame state
  logic [DIM_W-1:0]   mdl_width  = WIDTH_RST;
  logic [DIM_W-1:0]   mdl_height = HEIGHT_RST;
  logic [LEVEL_W-1:0] mdl_level  = LEVEL_RST;
  logic [11:0]        col_pos    = '0;
  logic [11:0]        row_pos    = '0;
  logic [35:0]        col_sum    = '0;
  logic [35:0]        row_sum    = '0;
  logic [TOTAL_W-1:0] hit_count  = '0;

  logic [LEVEL_W-1:0] pixel_fifo[$];
  centroid_t          expected_centroids[$];

  int pushed_cnt     = 0;
  int accepted_cnt   = 0;
  int centroids_seen = 0;
  int mismatches     = 0;
  int cfg_writes     = 0;
  int cycle_cnt      = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int maxv);
    if (v == '0) return DIM_W'(1);
    if (int'(v) > maxv) return maxv[DIM_W-1:0];
    return v;
  endfunction

  // Account one pixel; queue a centroid at the end of a frame
  task automatic accumulate_pixel(input logic [LEVEL_W-1:0] pix);
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [DIM_W-1:0] col_nxt;
    logic [DIM_W-1:0] row_nxt;
    centroid_t        c;
    w_eff = clamp_dim(mdl_width, MAX_WIDTH_DEF);
    h_eff = clamp_dim(mdl_height, MAX_HEIGHT_DEF);
    if (pix == mdl_level) begin
      col_sum   = col_sum + col_pos;
      row_sum   = row_sum + row_pos;
      hit_count = hit_count + 1'b1;
    end
    col_nxt = {1'b0, col_pos} + 1'b1;
    if (col_nxt < w_eff) begin
      col_pos = col_nxt[11:0];
      return;
    end
    col_pos = '0;
    row_nxt = {1'b0, row_pos} + 1'b1;
    if (row_nxt < h_eff) begin
      row_pos = row_nxt[11:0];
      return;
    end
    row_pos = '0;
    c.found = (hit_count != '0);
    c.total = hit_count;
    if (c.found) begin
      c.cx = 12'(col_sum / hit_count);
      c.cy = 12'(row_sum / hit_count);
    end else begin
      c.cx = '0;
      c.cy = '0;
    end
    expected_centroids.push_back(c);
    col_sum   = '0;
    row_sum   = '0;
    hit_count = '0;
  endtask

  // Pixel driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pixel_fifo.size() == 0 || $urandom_range(99) < send_idle_pct) begin
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i    <= 1'b1;
        pixel_value_i <= pixel_fifo.pop_front();
      end
    end
  end

  // Result receiver backpressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: predict on accepted pixels, check accepted results
  always @(posedge clk_i) begin
    centroid_t c;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        centroids_seen++;
        if (expected_centroids.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected centroid: x=%0d y=%0d found=%0b total=%0d",
                     center_x_o, center_y_o, found_o, match_total_o);
        end else begin
          c = expected_centroids.pop_front();
          if (c.cx !== center_x_o || c.cy !== center_y_o || c.found !== found_o ||
              c.total !== match_total_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"centroid mismatch: exp x=%0d y=%0d found=%0b total=%0d, ",
                        "got x=%0d y=%0d found=%0b total=%0d"},
                       c.cx, c.cy, c.found, c.total,
                       center_x_o, center_y_o, found_o, match_total_o);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        accepted_cnt++;
        accumulate_pixel(pixel_value_i);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic push_pixel(input logic [LEVEL_W-1:0] p);
    pixel_fifo.push_back(p);
    pushed_cnt++;
  endtask

  // Hold until every pixel is taken and every centroid has come out
  task automatic settle();
    while (accepted_cnt != pushed_cnt || expected_centroids.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  mdl_width = data;
      REG_FRAME_HEIGHT: mdl_height = data;
      REG_MATCH_LEVEL:  mdl_level = data[LEVEL_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
  endtask

  // One random stretch: new level, usually new geometry, then whole frames, sometimes a ragged tail
  task automatic random_frames(output int n);
    int               pick;
    int               w;
    int               h;
    int               frame_px;
    int               mpct;
    logic [LEVEL_W-1:0] lvl;
    pick = $urandom_range(99);
    if (pick < 10) w = 0;
    else if (pick < 25) w = $urandom_range(13, 40);
    else w = $urandom_range(1, 12);
    h = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 6);
    pick = $urandom_range(99);
    if (pick < 20) lvl = 8'h00;
    else if (pick < 40) lvl = 8'hFF;
    else lvl = 8'($urandom_range(255));
    settle();
    if ($urandom_range(3) != 0) begin
      write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
      write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    end
    write_reg(REG_MATCH_LEVEL, CFG_DATA_W'(lvl));
    frame_px = clamp_dim(mdl_width, MAX_WIDTH_DEF) * clamp_dim(mdl_height, MAX_HEIGHT_DEF);
    n = $urandom_range(1, 3) * frame_px;
    if ($urandom_range(99) < 20) n += $urandom_range(1, frame_px);
    mpct = $urandom_range(0, 90);
    for (int i = 0; i < n; i++)
      push_pixel(($urandom_range(99) < mpct) ? mdl_level : 8'($urandom_range(255)));
  endtask

  initial begin
    int n;
    int mode_items;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: a few pixels at reset geometry, then degenerate 1x1 frames
    push_pixel(8'hFF);
    push_pixel(8'h00);
    push_pixel(8'hFF);
    push_pixel(8'h11);
    settle();
    write_reg(REG_FRAME_WIDTH, 13'd0);
    write_reg(REG_FRAME_HEIGHT, 13'd0);
    push_pixel(8'hFF);
    push_pixel(8'h00);
    push_pixel(8'hFF);
    settle();
    // Write to an unused index must leave the level alone
    write_reg(REG_UNUSED, 13'h1FFF);
    push_pixel(8'hFF);
    push_pixel(8'h00);
    settle();
    write_reg(REG_MATCH_LEVEL, 13'h000);
    push_pixel(8'h00);
    push_pixel(8'hFF);
    settle();
    // Shrink the width mid-frame with the column already past the new limit
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    write_reg(REG_MATCH_LEVEL, 13'd200);
    push_pixel(8'd200);
    push_pixel(8'd1);
    push_pixel(8'd200);
    push_pixel(8'd200);
    push_pixel(8'd7);
    settle();
    write_reg(REG_FRAME_WIDTH, 13'd2);
    push_pixel(8'd200);
    push_pixel(8'd200);
    push_pixel(8'd3);
    push_pixel(8'd200);
    push_pixel(8'd200);
    push_pixel(8'd200);
    settle();
    write_reg(REG_FRAME_WIDTH, 13'd1);
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    push_pixel(8'd200);
    push_pixel(8'd201);

    // Random: three backpressure profiles
    for (int mode = 0; mode < 3; mode++) begin
      settle();
      case (mode)
        0: begin send_idle_pct = 7;  recv_idle_pct = 64; end
        1: begin send_idle_pct = 64; recv_idle_pct = 7;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      mode_items = 0;
      while (mode_items < 250) begin
        random_frames(n);
        mode_items += n;
      end
    end

    settle();
    $display("pixels sent %0d, centroids checked %0d, register writes %0d",
             accepted_cnt, centroids_seen, cfg_writes);
    $display("mismatches %0d over 1x1 up to 240-pixel frames and mid-frame geometry changes",
             mismatches);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

/* binary_blob_centroid_core.f */
sv/bbc_pkg.sv
sv/bbc_serdiv.sv
sv/bbc_accum.sv
sv/binary_blob_centroid_core.sv
sv/bbc_checker.sv
tb/tb.sv
